/* sv/f2mn_pkg.sv */
package f2mn_pkg;

  // Mantissa carried with 31 fraction bits, value in [1,2)
  localparam int unsigned MANT_W = 32;
  localparam int unsigned FREQ_W = 24;
  localparam int unsigned MSB_W  = 5;

  // Control and payload that travel down the cell chain with each request
  typedef struct packed {
    logic              valid;
    logic              nz;
    logic [MANT_W-1:0] mant;
    logic [15:0]       amp;
    logic [3:0]        chan;
  } f2mn_ctl_t;

endpackage

/* sv/f2mn_log_cell.sv */
// One squaring step of the log2 fraction: square the mantissa, emit one bit.
module f2mn_log_cell
  import f2mn_pkg::*;
#(
  parameter int unsigned FW = 16,
  parameter int unsigned POS = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  f2mn_ctl_t     ctl_in,
  input  logic [MSB_W-1:0] msb_in,
  input  logic [FW-1:0] frac_in,
  output f2mn_ctl_t     ctl_out,
  output logic [MSB_W-1:0] msb_out,
  output logic [FW-1:0] frac_out
);

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     m2;
  logic                bit_set;
  logic [MANT_W-1:0]   m_next;
  logic [FW-1:0]       frac_next;

  // Square and renormalize
  always_comb begin
    sq        = {{MANT_W{1'b0}}, ctl_in.mant} * {{MANT_W{1'b0}}, ctl_in.mant};
    m2        = sq[MANT_W+31:31];
    bit_set   = m2[MANT_W];
    m_next    = bit_set ? m2[MANT_W:1] : m2[MANT_W-1:0];
    frac_next = frac_in;
    frac_next[FW-1-POS] = bit_set;
  end

  // Hand the request to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (advance) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl_out.nz   <= ctl_in.nz;
      ctl_out.mant <= m_next;
      ctl_out.amp  <= ctl_in.amp;
      ctl_out.chan <= ctl_in.chan;
      msb_out      <= msb_in;
      frac_out     <= frac_next;
    end
  end

endmodule

/* sv/f2mn_finish.sv */
// Turn log2 into note, cents and velocity over three registered stages.
module f2mn_finish
  import f2mn_pkg::*;
#(
  parameter int unsigned FW = 16,
  parameter int unsigned FFB = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  f2mn_ctl_t        ctl_in,
  input  logic [MSB_W-1:0] msb_in,
  input  logic [FW-1:0]    frac_in,
  input  logic [MSB_W+FW-1:0] log440,
  output logic             valid_out,
  output logic             note_valid,
  output logic [6:0]       note_number,
  output logic [14:0]      cents_offset,
  output logic [6:0]       velocity,
  output logic [3:0]       channel_out
);

  localparam int unsigned SW = MSB_W + FW + 8;

  // Stage A: semitone value and velocity
  logic              va;
  logic              nz_a;
  logic signed [SW-1:0] s_a;
  logic [6:0]        vel_a;
  logic [3:0]        ch_a;
  // Stage B: rounded note and difference
  logic              vb;
  logic              nz_b;
  logic [6:0]        note_b;
  logic signed [SW-1:0] d_b;
  logic [6:0]        vel_b;
  logic [3:0]        ch_b;

  logic signed [SW-1:0] lg, s_next, mag_s, rs;
  logic [15:0]       ampc;
  logic [23:0]       vprod;
  logic signed [SW-1:0] note_fx;
  logic signed [SW+7:0] c100, cmag, cr;
  logic signed [SW-1:0] half;

  always_comb begin
    half   = SW'(1) <<< (FW - 1);
    lg     = SW'({msb_in, frac_in}) - SW'(log440) - (SW'(FFB) <<< FW);
    s_next = (SW'(69) <<< FW) + lg * SW'(12);
    // clamp amplitude to 0..1.0
    if (ctl_in.amp[15]) ampc = '0;
    else if (ctl_in.amp > 16'd16384) ampc = 16'd16384;
    else ampc = ctl_in.amp;
    vprod = 24'(ampc) * 24'd127 + 24'd8192;
  end

  always_comb begin
    mag_s = s_a[SW-1] ? -s_a : s_a;
    rs    = (mag_s + half) >>> FW;
    if (s_a[SW-1]) rs = -rs;
    note_fx = rs;
    if (rs < 0) note_fx = '0;
    else if (rs > SW'(127)) note_fx = SW'(127);
  end

  always_comb begin
    c100 = (SW+8)'(d_b) * (SW+8)'(100);
    cmag = c100[SW+7] ? -c100 : c100;
    cr   = (cmag + (SW+8)'(half)) >>> FW;
    if (c100[SW+7]) cr = -cr;
    if (cr < -(SW+8)'(16384)) cr = -(SW+8)'(16384);
    else if (cr > (SW+8)'(16383)) cr = (SW+8)'(16383);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      valid_out <= 1'b0;
    end else if (advance) begin
      va <= ctl_in.valid;
      vb <= va;
      valid_out <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nz_a  <= ctl_in.nz;
      s_a   <= s_next;
      vel_a <= vprod[20:14];
      ch_a  <= ctl_in.chan;
      nz_b   <= nz_a;
      note_b <= note_fx[6:0];
      d_b    <= s_a - (note_fx <<< FW);
      vel_b  <= vel_a;
      ch_b   <= ch_a;
      note_valid   <= nz_b;
      note_number  <= nz_b ? note_b : 7'd0;
      cents_offset <= nz_b ? cr[14:0] : 15'd0;
      velocity     <= nz_b ? vel_b : 7'd0;
      channel_out  <= ch_b;
    end
  end

endmodule

/* sv/frequency_to_midi_note.sv */
// Frequency to MIDI note converter. Accepts one request per clock unless stalled
// and returns one result per request. The path is a chain of squaring cells,
// one per fraction bit of log2, plus input and three output stages.
// Stall from downstream freezes the whole chain.
module frequency_to_midi_note
  import f2mn_pkg::*;
#(
  parameter int unsigned FREQ_FRAC_BITS = 8,
  parameter int unsigned LOG_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] freq_hz_q8,
  input  logic signed [15:0] amplitude_q14,
  input  logic signed [7:0]  channel_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        note_valid,
  output logic [6:0]  note_number,
  output logic signed [14:0] cents_offset,
  output logic [6:0]  velocity,
  output logic [3:0]  channel_out
);

  localparam int unsigned FW = LOG_FRAC_BITS;

  f2mn_ctl_t           ctl  [FW+1];
  logic [MSB_W-1:0]    msb  [FW+1];
  logic [FW-1:0]       frac [FW+1];
  logic                advance;
  logic [MSB_W-1:0]    msb_in;
  logic [MANT_W-1:0]   mant_in;
  logic [3:0]          chan_in;
  logic [MSB_W+FW-1:0] log440;

  // Chain moves whenever the output slot is free or being taken
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Leading-one position, normalized mantissa and clamped channel
  always_comb begin
    msb_in = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (freq_hz_q8[i]) msb_in = MSB_W'(i);
    end
    mant_in = MANT_W'({8'd0, freq_hz_q8} << (5'd31 - msb_in));
    if (channel_request[7]) chan_in = 4'd0;
    else if (channel_request > 8'sd15) chan_in = 4'd15;
    else chan_in = channel_request[3:0];
  end

  // Constant log2(440) computed by the same squaring recurrence
  always_comb begin
    logic [2*MANT_W-1:0] m;
    m = 64'd440 << 23;
    log440 = '0;
    log440[MSB_W+FW-1:FW] = MSB_W'(8);
    for (int k = 0; k < FW; k++) begin
      m = (m * m) >> 31;
      if (m[32]) begin
        log440[FW-1-k] = 1'b1;
        m = m >> 1;
      end
    end
  end

  // Input register at the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else if (advance) begin
      ctl[0].valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl[0].nz   <= freq_hz_q8 != 24'd0;
      ctl[0].mant <= mant_in;
      ctl[0].amp  <= amplitude_q14;
      ctl[0].chan <= chan_in;
      msb[0]      <= msb_in;
      frac[0]     <= '0;
    end
  end

  for (genvar g = 0; g < FW; g++) begin : g_cell
    f2mn_log_cell #(.FW(FW), .POS(g)) u_cell (
      .clk, .rst, .advance,
      .ctl_in(ctl[g]), .msb_in(msb[g]), .frac_in(frac[g]),
      .ctl_out(ctl[g+1]), .msb_out(msb[g+1]), .frac_out(frac[g+1])
    );
  end

  f2mn_finish #(.FW(FW), .FFB(FREQ_FRAC_BITS)) u_finish (
    .clk, .rst, .advance,
    .ctl_in(ctl[FW]), .msb_in(msb[FW]), .frac_in(frac[FW]), .log440,
    .valid_out(out_valid), .note_valid, .note_number,
    .cents_offset(cents_offset), .velocity, .channel_out
  );

`ifndef SYNTHESIS
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !note_valid) |-> (note_number == 7'd0 && cents_offset == 15'sd0
                                    && velocity == 7'd0))
    else $error("nonzero fields without a note");
`endif

endmodule

/* sim/tb_top.sv */
module tb_top;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [23:0] freq_hz_q8;
  logic signed [15:0] amplitude_q14;
  logic signed [7:0]  channel_request;
  logic        out_valid;
  logic        out_stall;
  logic        note_valid;
  logic [6:0]  note_number;
  logic signed [14:0] cents_offset;
  logic [6:0]  velocity;
  logic [3:0]  channel_out;

  localparam int FRAC_IN  = 8;
  localparam int FRAC_LOG = 16;
  localparam int N_RANDOM = 1550;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic        nv;
    logic [6:0]  note;
    logic [14:0] cents;
    logic [6:0]  vel;
    logic [3:0]  chan;
  } note_desc_t;

  // Directed row: request plus optional hand-typed expectation
  typedef struct {
    logic [23:0] freq;
    logic [15:0] amp;
    logic [7:0]  chan;
    bit          typed;
    note_desc_t  want;
  } row_t;

  note_desc_t pending_notes[$];
  int mismatches;
  bit send_done;

  frequency_to_midi_note i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .freq_hz_q8(freq_hz_q8), .amplitude_q14(amplitude_q14),
    .channel_request(channel_request),
    .out_valid(out_valid), .out_stall(out_stall),
    .note_valid(note_valid), .note_number(note_number),
    .cents_offset(cents_offset), .velocity(velocity), .channel_out(channel_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Truncated fixed-point log2 by repeated mantissa squaring
  function automatic longint log2_fixed(input logic [31:0] x);
    int msb;
    logic [63:0] m;
    longint frac;
    msb = 0;
    frac = 0;
    for (int b = 31; b >= 0; b--) begin
      if (x[b]) begin
        msb = b;
        break;
      end
    end
    m = 64'(x) << (31 - msb);
    for (int i = 0; i < FRAC_LOG; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(msb) << FRAC_LOG) | frac;
  endfunction

  function automatic longint round_away(input longint v);
    longint half;
    half = longint'(1) << (FRAC_LOG - 1);
    if (v >= 0) return (v + half) >>> FRAC_LOG;
    return -((-v + half) >>> FRAC_LOG);
  endfunction

  function automatic note_desc_t predict_note(input logic [23:0] f,
                                              input logic signed [15:0] a,
                                              input logic signed [7:0] c);
    note_desc_t r;
    longint s, n, ct, av;
    r = '{1'b0, 7'd0, 15'd0, 7'd0, 4'd0};
    if (c < 0) r.chan = 4'd0;
    else if (c > 15) r.chan = 4'd15;
    else r.chan = c[3:0];
    if (f != 0) begin
      r.nv = 1'b1;
      s = (longint'(69) << FRAC_LOG) + 12 * (log2_fixed({8'd0, f})
          - log2_fixed(32'd440) - (longint'(FRAC_IN) << FRAC_LOG));
      n = round_away(s);
      if (n < 0) n = 0;
      if (n > 127) n = 127;
      ct = round_away((s - (n << FRAC_LOG)) * 100);
      if (ct < -16384) ct = -16384;
      if (ct > 16383) ct = 16383;
      r.note = n[6:0];
      r.cents = ct[14:0];
      av = a;
      if (av < 0) av = 0;
      if (av > 16384) av = 16384;
      av = (av * 127 + 8192) >>> 14;
      if (av > 127) av = 127;
      r.vel = av[6:0];
    end
    return r;
  endfunction

  // Drive one request and hold it until accepted
  task automatic send_request(input logic [23:0] f, input logic [15:0] a,
                              input logic [7:0] c, input note_desc_t want);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    freq_hz_q8 <= f;
    amplitude_q14 <= a;
    channel_request <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_notes.push_back(want);
  endtask

  // Directed stimulus and random requests
  initial begin
    row_t rows[$];
    note_desc_t exp_n;
    logic [23:0] f;
    logic [15:0] a;
    logic [7:0] c;
    int k;
    rst = 1'b1;
    in_valid = 1'b0;
    freq_hz_q8 = '0;
    amplitude_q14 = '0;
    channel_request = '0;
    send_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero frequency, typed expectations
    rows.push_back('{24'd0, 16'h7FFF, 8'h80, 1, '{1'b0, 7'd0, 15'd0, 7'd0, 4'd0}});
    rows.push_back('{24'd0, 16'h8000, 8'h7F, 1, '{1'b0, 7'd0, 15'd0, 7'd0, 4'd15}});
    rows.push_back('{24'd0, 16'h4000, 8'd7, 1, '{1'b0, 7'd0, 15'd0, 7'd0, 4'd7}});
    // 440 Hz exactly with full, negative and overrange amplitude: note 69, no offset
    rows.push_back('{24'd112640, 16'h4000, 8'd0, 1, '{1'b1, 7'd69, 15'd0, 7'd127, 4'd0}});
    rows.push_back('{24'd112640, 16'h8000, 8'hFF, 1, '{1'b1, 7'd69, 15'd0, 7'd0, 4'd0}});
    rows.push_back('{24'd112640, 16'h7FFF, 8'd16, 1, '{1'b1, 7'd69, 15'd0, 7'd127, 4'd15}});
    // extremes and clamps, checked by prediction
    rows.push_back('{24'd1, 16'h0000, 8'd15, 0, '{default:'0}});
    rows.push_back('{24'hFFFFFF, 16'h0001, 8'd1, 0, '{default:'0}});
    rows.push_back('{24'hAAAAAA, 16'h2000, 8'h55, 0, '{default:'0}});
    rows.push_back('{24'h555555, 16'h4001, 8'hAA, 0, '{default:'0}});
    rows.push_back('{24'd2093, 16'h3FFF, 8'd9, 0, '{default:'0}});
    rows.push_back('{24'd256, 16'hFFFF, 8'd3, 0, '{default:'0}});
    rows.push_back('{24'd3200000, 16'h0040, 8'd14, 0, '{default:'0}});
    rows.push_back('{24'd2100, 16'h1234, 8'd2, 0, '{default:'0}});
    rows.push_back('{24'd4186, 16'h00A1, 8'd5, 0, '{default:'0}});

    foreach (rows[i]) begin
      exp_n = rows[i].typed ? rows[i].want
              : predict_note(rows[i].freq, rows[i].amp, rows[i].chan);
      send_request(rows[i].freq, rows[i].amp, rows[i].chan, exp_n);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      k = $urandom_range(0, 9);
      // mostly audio range, some full range and zero
      if (k < 6) f = 24'($urandom_range(5120, 5120000));
      else if (k < 9) f = 24'($urandom);
      else f = 24'd0;
      a = 16'($urandom);
      if ($urandom_range(0, 1)) a = 16'($urandom_range(0, 16384));
      c = 8'($urandom);
      if ($urandom_range(0, 1)) c = 8'($urandom_range(0, 17));
      send_request(f, a, c, predict_note(f, a, c));
    end
    in_valid <= 1'b0;
    send_done = 1'b1;
  end

  // Randomly stall the result side; compare accepted results
  initial begin
    note_desc_t e;
    int stall_left;
    out_stall = 1'b1;
    mismatches = 0;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_notes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at %0t", $time);
        end else begin
          e = pending_notes.pop_front();
          if (note_valid !== e.nv || note_number !== e.note ||
              cents_offset !== e.cents || velocity !== e.vel ||
              channel_out !== e.chan) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp nv=%0d note=%0d cents=%0d vel=%0d ch=%0d",
                        " got %0d %0d %0d %0d %0d"},
                       e.nv, e.note, $signed(e.cents), e.vel, e.chan, note_valid,
                       note_number, cents_offset, velocity, channel_out);
          end
          stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Drain and report
  initial begin
    wait (send_done);
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_notes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
